// File: rtl/pdf_pkg.sv
// Package for the particle drag force block: item and config types,
// fixed-point constants, stage schedule, and shared arithmetic helpers.
// No dependencies.
package pdf_pkg;

  localparam int DW = 32;
  localparam int FB = 20;
  localparam int MW = DW - 1;
  localparam int AW = 4;

  typedef logic [MW-1:0] mag_t;

  localparam mag_t MAXMAG = '1;
  localparam mag_t E83    = mag_t'((64'd8 << FB) / 3);
  localparam logic [61:0] PI4    = 62'h3243F6A8885A308D;
  localparam logic [31:0] PI_HI  = PI4[61:30];
  localparam logic [29:0] PI_LO  = PI4[29:0];
  localparam logic [31:0] RECIP3 = 32'hAAAAAAAB;

  localparam logic [1:0] REG_GRAV      = 2'd0;
  localparam logic [1:0] REG_SIGMA     = 2'd1;
  localparam logic [1:0] REG_TWO_PHASE = 2'd2;
  localparam logic [1:0] REG_DIM3      = 2'd3;

  // stage schedule of the cell chain
  localparam int ST_SLIP      = 0;
  localparam int ST_SQ        = 1;
  localparam int ST_SUM       = 2;
  localparam int ST_MSQ0      = 3;
  localparam int ST_MSQ_LAST  = 34;
  localparam int ST_X         = 3;
  localparam int ST_EDIV_INIT = 4;
  localparam int ST_EDIV0     = 5;
  localparam int ST_EDIV_LAST = 35;
  localparam int ST_NORM      = 35;
  localparam int ST_ESQ_INIT  = 36;
  localparam int ST_ESQ0      = 37;
  localparam int ST_ESQ_LAST  = 62;
  localparam int ST_RN        = 36;
  localparam int ST_P         = 37;
  localparam int ST_RDIV_INIT = 38;
  localparam int ST_RDIV0     = 39;
  localparam int ST_RDIV_LAST = 69;
  localparam int ST_CDD       = 63;
  localparam int ST_RE        = 70;
  localparam int ST_CDIV0     = 71;
  localparam int ST_CDIV_LAST = 101;
  localparam int ST_CDP       = 102;
  localparam int ST_CD        = 103;
  localparam int ST_CR        = 104;
  localparam int ST_CRS       = 105;
  localparam int ST_A         = 106;
  localparam int ST_FORCE     = 107;
  localparam int NSTAGES      = 108;
  localparam int STEP_W       = $clog2(NSTAGES);

  typedef logic [STEP_W-1:0] step_t;

  typedef struct packed {
    logic ovf;
    mag_t v;
  } fm_t;

  typedef struct packed {
    logic        big;
    logic [31:0] r;
    mag_t        q;
    mag_t        nlo;
  } div_t;

  typedef struct packed {
    logic [63:0] rem;
    logic [31:0] root;
  } sq_t;

  typedef struct packed {
    mag_t g;
    mag_t sigma;
    logic two_ph;
    logic dim3;
  } cfg_t;

  typedef struct packed {
    logic             vld;
    logic             sat;
    logic             dd_ovf;
    logic [2:0][31:0] pv;
    logic [2:0][31:0] fv;
    mag_t             rho;
    mag_t             mu;
    mag_t             d;
    mag_t             rp;
    logic [2:0][30:0] dm;
    logic [2:0]       dn;
    logic [2:0][61:0] sq;
    sq_t              msq;
    sq_t              esq;
    mag_t             dd;
    mag_t             ddg;
    mag_t             drho;
    mag_t             x;
    mag_t             norm;
    mag_t             rn;
    mag_t             p;
    mag_t             cdp;
    mag_t             cdd;
    mag_t             cd;
    mag_t             s;
    mag_t             cr;
    mag_t             crs;
    mag_t             a;
    logic [62:0]      pih;
    logic [60:0]      pil;
    div_t             ediv;
    div_t             rdiv;
    logic [2:0][31:0] f;
  } item_t;

  function automatic fm_t fmul(mag_t a, mag_t b);
    logic [2*MW-1:0] p;
    fm_t r;
    p = a * b;
    r.ovf = |p[2*MW-1:FB+MW];
    r.v = r.ovf ? MAXMAG : p[FB+MW-1:FB];
    return r;
  endfunction

  function automatic div_t div_init(logic [63:0] n, mag_t dv);
    div_t s;
    s.big = n >= {2'b0, dv, 31'b0};
    s.r = n[62:31];
    s.q = '0;
    s.nlo = n[30:0];
    return s;
  endfunction

  function automatic div_t div_step(div_t s, mag_t dv, logic [4:0] k);
    logic [31:0] t;
    div_t o;
    o = s;
    t = {s.r[30:0], s.nlo[k]};
    if (t >= {1'b0, dv}) begin
      t = t - {1'b0, dv};
      o.q[k] = 1'b1;
    end
    o.r = t;
    return o;
  endfunction

  function automatic fm_t div_result(div_t s);
    fm_t r;
    r.ovf = s.big;
    r.v = s.big ? MAXMAG : s.q;
    return r;
  endfunction

  function automatic sq_t sqrt_step(sq_t s, logic [4:0] b);
    logic [65:0] t;
    logic [65:0] x;
    sq_t o;
    o = s;
    t = ({34'b0, s.root} << ({1'b0, b} + 6'd1)) + (66'd1 << {b, 1'b0});
    x = {2'b0, s.rem};
    if (x >= t) begin
      o.rem = 64'(x - t);
      o.root[b] = 1'b1;
    end
    return o;
  endfunction

endpackage

// File: rtl/pdf_regs.sv
// Configuration registers of the drag force block behind an APB-style port.
// Depends on pdf_pkg.
module pdf_regs (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [pdf_pkg::AW-1:0] paddr,
  input  logic [31:0]           pwdata,
  output logic [31:0]           prdata,
  output logic                  pready,
  output pdf_pkg::cfg_t         cfg
);
  import pdf_pkg::*;

  logic       wr;
  logic [1:0] idx;

  assign pready = 1'b1;
  assign idx = paddr[3:2];
  assign wr = psel & penable & pwrite & pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.g <= '0;
      cfg.sigma <= '0;
      cfg.two_ph <= 1'b0;
      cfg.dim3 <= 1'b1;
    end else if (wr) begin
      case (idx)
        REG_GRAV:      cfg.g <= pwdata[MW-1:0];
        REG_SIGMA:     cfg.sigma <= pwdata[MW-1:0];
        REG_TWO_PHASE: cfg.two_ph <= pwdata[0];
        REG_DIM3:      cfg.dim3 <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_GRAV:      prdata = {1'b0, cfg.g};
      REG_SIGMA:     prdata = {1'b0, cfg.sigma};
      REG_TWO_PHASE: prdata = {31'b0, cfg.two_ph};
      REG_DIM3:      prdata = {31'b0, cfg.dim3};
      default:       prdata = '0;
    endcase
  end

endmodule

// File: rtl/pdf_cell.sv
// One cell of the drag force chain: does the work of its stage on the item
// and hands it to the next cell. Depends on pdf_pkg.
module pdf_cell (
  input  logic           clk,
  input  logic           rst,
  input  pdf_pkg::step_t step,
  input  pdf_pkg::cfg_t  cfg,
  input  pdf_pkg::item_t din,
  output pdf_pkg::item_t dout
);
  import pdf_pkg::*;

  item_t       n;
  logic [31:0] mp, mf;
  logic        sp, sf, sg;
  logic [32:0] m33;
  fm_t         fr;
  logic [93:0] s94;
  logic [58:0] p3;
  logic [25:0] q3;
  logic [61:0] pf;
  mag_t        mf_v;
  logic        fovf;

  always_comb begin
    n = din;
    mp = '0; mf = '0; sp = 1'b0; sf = 1'b0; sg = 1'b0; m33 = '0;
    fr = '0; s94 = '0; p3 = '0; q3 = '0; pf = '0; mf_v = '0; fovf = 1'b0;

    if (step == ST_SLIP) begin
      for (int j = 0; j < 3; j++) begin
        sp = din.pv[j][31];
        mp = sp ? 32'(-din.pv[j]) : din.pv[j];
        sf = !din.fv[j][31];
        mf = din.fv[j][31] ? 32'(-din.fv[j]) : din.fv[j];
        if (sp == sf) begin
          m33 = {1'b0, mp} + {1'b0, mf};
          sg = sp;
        end else if (mp >= mf) begin
          m33 = {1'b0, mp - mf};
          sg = sp;
        end else begin
          m33 = {1'b0, mf - mp};
          sg = sf;
        end
        if (j == 2 && !cfg.dim3) begin
          n.dm[j] = '0;
          n.dn[j] = 1'b0;
        end else begin
          if (m33 > {2'b0, MAXMAG}) begin
            n.dm[j] = MAXMAG;
            n.sat = 1'b1;
          end else begin
            n.dm[j] = m33[30:0];
          end
          n.dn[j] = (m33 != '0) && sg;
        end
      end
    end

    if (step == ST_SQ) begin
      for (int j = 0; j < 3; j++) n.sq[j] = din.dm[j] * din.dm[j];
      fr = fmul(din.d, din.d);
      n.dd = fr.v;
      n.dd_ovf = fr.ovf;
    end

    if (step == ST_SUM) begin
      n.msq.rem = 64'(din.sq[0]) + 64'(din.sq[1]) + 64'(din.sq[2]);
      n.msq.root = '0;
      n.ddg = fmul(din.dd, cfg.g).v;
      n.drho = (din.rho >= din.rp) ? din.rho - din.rp : din.rp - din.rho;
      n.pih = din.dd * PI_HI;
      n.pil = din.dd * PI_LO;
    end

    if (step inside {[ST_MSQ0:ST_MSQ_LAST]})
      n.msq = sqrt_step(din.msq, 5'(ST_MSQ_LAST - int'(step)));

    if (step == ST_X) begin
      n.x = fmul(din.ddg, din.drho).v;
      s94 = {1'b0, din.pih, 30'b0} + 94'(din.pil);
      n.s = s94[92:62];
    end

    if (step == ST_EDIV_INIT)
      n.ediv = div_init({13'b0, din.x, 20'b0}, cfg.sigma);

    if (step inside {[ST_EDIV0:ST_EDIV_LAST]})
      n.ediv = div_step(din.ediv, cfg.sigma, 5'(ST_EDIV_LAST - int'(step)));

    if (step == ST_NORM) begin
      if (din.msq.root[31]) begin
        n.norm = MAXMAG;
        n.sat = 1'b1;
      end else begin
        n.norm = din.msq.root[30:0];
      end
    end

    if (step == ST_ESQ_INIT) begin
      n.esq.rem = {13'b0, div_result(din.ediv).v, 20'b0};
      n.esq.root = '0;
    end

    if (step inside {[ST_ESQ0:ST_ESQ_LAST]})
      n.esq = sqrt_step(din.esq, 5'(ST_ESQ_LAST - int'(step)));

    if (step == ST_RN) begin
      fr = fmul(din.rho, din.norm);
      n.rn = fr.v;
      n.sat = n.sat | fr.ovf;
    end

    if (step == ST_P) begin
      fr = fmul(din.rn, din.d);
      n.p = fr.v;
      n.sat = n.sat | fr.ovf;
    end

    if (step == ST_RDIV_INIT)
      n.rdiv = div_init({13'b0, din.p, 20'b0}, din.mu);

    if (step inside {[ST_RDIV0:ST_RDIV_LAST]})
      n.rdiv = div_step(din.rdiv, din.mu, 5'(ST_RDIV_LAST - int'(step)));

    if (step == ST_CDD) begin
      p3 = {din.esq.root[25:0], 1'b0} * RECIP3;
      q3 = p3[58:33];
      if (!cfg.two_ph) n.cdd = '0;
      else if (cfg.sigma == '0) n.cdd = E83;
      else n.cdd = ({5'b0, q3} > E83) ? E83 : {5'b0, q3};
    end

    // p carries Re from here on as the divisor of 24/Re
    if (step == ST_RE) begin
      fr = div_result(din.rdiv);
      if (din.mu != '0) n.sat = n.sat | fr.ovf;
      if (fr.v == '0) fr.v = mag_t'(1);
      n.p = fr.v;
      n.rdiv = div_init(64'd24 << (2 * FB), fr.v);
    end

    if (step inside {[ST_CDIV0:ST_CDIV_LAST]})
      n.rdiv = div_step(din.rdiv, din.p, 5'(ST_CDIV_LAST - int'(step)));

    if (step == ST_CDP) begin
      fr = div_result(din.rdiv);
      if (din.mu != '0) begin
        n.cdp = fr.v;
        n.sat = n.sat | fr.ovf;
      end else begin
        n.cdp = '0;
      end
    end

    if (step == ST_CD) begin
      n.cd = (din.cdp > din.cdd) ? din.cdp : din.cdd;
      if (cfg.dim3) n.sat = n.sat | din.dd_ovf;
      else n.s = din.d;
    end

    if (step == ST_CR) begin
      fr = fmul(din.cd, din.rho);
      n.cr = fr.v;
      n.sat = n.sat | fr.ovf;
    end

    if (step == ST_CRS) begin
      fr = fmul(din.cr, din.s);
      n.crs = fr.v;
      n.sat = n.sat | fr.ovf;
    end

    if (step == ST_A) begin
      fr = fmul(din.crs, din.norm);
      n.a = fr.v;
      n.sat = n.sat | fr.ovf;
    end

    if (step == ST_FORCE) begin
      for (int j = 0; j < 3; j++) begin
        pf = din.a * din.dm[j];
        fovf = |pf[61:52];
        mf_v = fovf ? MAXMAG : pf[51:21];
        if (j == 2 && !cfg.dim3) begin
          n.f[j] = '0;
        end else begin
          n.sat = n.sat | fovf;
          n.f[j] = (mf_v != '0 && !din.dn[j]) ? 32'(-{1'b0, mf_v}) : {1'b0, mf_v};
        end
      end
    end

    if (rst) n.vld = 1'b0;
  end

  always_ff @(posedge clk) begin
    dout <= n;
  end

endmodule

// File: rtl/particle_drag_force.sv
// Particle drag force, top level: config registers and a chain of 108 cells.
// Each item is registered once per cell from the start edge to the done strobe; one item per cycle.
// The length is set by the bit-per-cell square root and divider stages.
// busy stays low; the receiver cannot stall and every result shows for one cycle.
// Synchronous active-high reset sets the config registers (dim3 to 1, the rest to 0) and drops all in-flight items.
// Depends on pdf_pkg, pdf_regs, pdf_cell.
module particle_drag_force (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   start,
  output logic                   busy,
  input  logic signed [31:0]     particle_vel_x,
  input  logic signed [31:0]     particle_vel_y,
  input  logic signed [31:0]     particle_vel_z,
  input  logic signed [31:0]     fluid_vel_x,
  input  logic signed [31:0]     fluid_vel_y,
  input  logic signed [31:0]     fluid_vel_z,
  input  logic [30:0]            fluid_density,
  input  logic [30:0]            fluid_viscosity,
  input  logic [30:0]            particle_diameter,
  input  logic [30:0]            particle_density,
  output logic                   done,
  output logic signed [31:0]     force_x,
  output logic signed [31:0]     force_y,
  output logic signed [31:0]     force_z,
  output logic                   saturated,
  input  logic                   psel,
  input  logic                   penable,
  input  logic                   pwrite,
  input  logic [pdf_pkg::AW-1:0] paddr,
  input  logic [31:0]            pwdata,
  output logic [31:0]            prdata,
  output logic                   pready
);
  import pdf_pkg::*;

  cfg_t  cfg;
  item_t pipe [NSTAGES+1];

  assign busy = 1'b0;

  pdf_regs u_regs (
    .clk(clk), .rst(rst), .psel(psel), .penable(penable), .pwrite(pwrite),
    .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready), .cfg(cfg)
  );

  always_comb begin
    pipe[0] = '0;
    pipe[0].vld = start & ~busy;
    pipe[0].pv[0] = particle_vel_x;
    pipe[0].pv[1] = particle_vel_y;
    pipe[0].pv[2] = particle_vel_z;
    pipe[0].fv[0] = fluid_vel_x;
    pipe[0].fv[1] = fluid_vel_y;
    pipe[0].fv[2] = fluid_vel_z;
    pipe[0].rho = fluid_density;
    pipe[0].mu = fluid_viscosity;
    pipe[0].d = particle_diameter;
    pipe[0].rp = particle_density;
  end

  for (genvar i = 0; i < NSTAGES; i++) begin : g_cell
    pdf_cell u_cell (
      .clk(clk), .rst(rst), .step(step_t'(i)), .cfg(cfg),
      .din(pipe[i]), .dout(pipe[i+1])
    );
  end

  assign done = pipe[NSTAGES].vld;
  assign force_x = pipe[NSTAGES].f[0];
  assign force_y = pipe[NSTAGES].f[1];
  assign force_z = pipe[NSTAGES].f[2];
  assign saturated = pipe[NSTAGES].sat;

endmodule

// File: rtl/pdf_checker.sv
// Port-level checks for particle_drag_force, attached by bind.
// Depends on the top level's ports only.
module pdf_checker (
  input logic        clk,
  input logic        rst,
  input logic        busy,
  input logic        done,
  input logic [31:0] force_x,
  input logic [31:0] force_y,
  input logic [31:0] force_z,
  input logic        pready
);

  a_no_done_after_reset: assert property (@(posedge clk) rst |=> !done)
    else $error("done after reset");

  a_force_symmetric: assert property (@(posedge clk) disable iff (rst)
    done |-> (force_x != 32'h80000000) && (force_y != 32'h80000000) &&
             (force_z != 32'h80000000))
    else $error("force outside symmetric range");

  a_never_busy: assert property (@(posedge clk) disable iff (rst) !busy)
    else $error("busy asserted");

  a_pready: assert property (@(posedge clk) pready)
    else $error("pready low");

endmodule

bind particle_drag_force pdf_checker u_pdf_checker (.*);

// File: sim/tb.sv
// Testbench for particle_drag_force: directed table then random items,
// checked against an in-bench drag force predictor over several register settings.
// Depends on pdf_pkg and the particle_drag_force RTL.
module tb;
  import pdf_pkg::*;

  typedef struct {
    logic signed [31:0] pv [3];
    logic signed [31:0] fv [3];
    logic [30:0] rho, mu, d, rp;
  } particle_t;

  typedef struct {
    logic [31:0] f [3];
    logic sat;
  } force_t;

  typedef struct {
    particle_t p;
    bit known;
    force_t r;
  } row_t;

  localparam logic [127:0] MAXW = 128'h7FFF_FFFF;
  localparam logic [127:0] PI4W = 128'h3243F6A8885A308D;

  logic clk = 0, rst = 1, start = 0;
  logic psel = 0, penable = 0, pwrite = 0;
  logic [AW-1:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic signed [31:0] pvx = 0, pvy = 0, pvz = 0, fvx = 0, fvy = 0, fvz = 0;
  logic [30:0] rho_i = 0, mu_i = 0, d_i = 0, rp_i = 0;
  logic busy, done, saturated, pready;
  logic signed [31:0] force_x, force_y, force_z;
  logic [31:0] prdata;

  logic [30:0] grav = 0, sigma = 0;
  logic two_ph = 0, dim3 = 1;
  force_t pending_forces [$];
  int errors = 0;
  int sent = 0;

  particle_drag_force dut (
    .clk, .rst, .start, .busy,
    .particle_vel_x(pvx), .particle_vel_y(pvy), .particle_vel_z(pvz),
    .fluid_vel_x(fvx), .fluid_vel_y(fvy), .fluid_vel_z(fvz),
    .fluid_density(rho_i), .fluid_viscosity(mu_i),
    .particle_diameter(d_i), .particle_density(rp_i),
    .done, .force_x, .force_y, .force_z, .saturated,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  always #5 clk = ~clk;

  function automatic logic [127:0] clip(logic [127:0] v, inout bit flag);
    if (v > MAXW) begin
      flag = 1;
      return MAXW;
    end
    return v;
  endfunction

  function automatic logic [127:0] qmul(logic [127:0] a, logic [127:0] b, inout bit flag);
    return clip((a * b) >> FB, flag);
  endfunction

  function automatic logic [127:0] root(logic [127:0] x);
    logic [127:0] r, c;
    r = 0;
    for (int b = 63; b >= 0; b--) begin
      c = r | (128'd1 << b);
      if (c * c <= x) r = c;
    end
    return r;
  endfunction

  function automatic force_t drag_force(particle_t p);
    force_t o;
    bit sat, ign, sp, sf, sg;
    logic [127:0] dm [3], mp, mf, m, sum, norm, rho, mu, d, rp, e83;
    logic [127:0] cdp, cdd, cd, s, a, pp, re, drho, x, q, r;
    bit dn [3];
    sat = 0;
    ign = 0;
    sum = 0;
    cdp = 0;
    cdd = 0;
    e83 = (128'd8 << FB) / 3;
    for (int j = 0; j < 3; j++) begin
      dm[j] = 0;
      dn[j] = 0;
      if (j == 2 && !dim3) continue;
      sp = p.pv[j][31];
      mp = sp ? 128'(-64'(p.pv[j])) : 128'(p.pv[j]);
      sf = !p.fv[j][31];
      mf = !sf ? 128'(-64'(p.fv[j])) : 128'(p.fv[j]);
      if (sp == sf) begin
        m = mp + mf;
        sg = sp;
      end else if (mp >= mf) begin
        m = mp - mf;
        sg = sp;
      end else begin
        m = mf - mp;
        sg = sf;
      end
      m = clip(m, sat);
      dm[j] = m;
      dn[j] = (m != 0) && sg;
      sum += m * m;
    end
    norm = clip(root(sum), sat);
    rho = p.rho;
    mu = p.mu;
    d = p.d;
    rp = p.rp;
    if (mu != 0) begin
      pp = qmul(qmul(rho, norm, sat), d, sat);
      re = clip((pp << FB) / mu, sat);
      if (re == 0) re = 1;
      cdp = clip((128'd24 << (2 * FB)) / re, sat);
    end
    if (two_ph) begin
      if (sigma == 0) cdd = e83;
      else begin
        drho = rho >= rp ? rho - rp : rp - rho;
        x = qmul(qmul(qmul(d, d, ign), 128'(grav), ign), drho, ign);
        q = clip((x << FB) / sigma, ign);
        r = root(q << FB);
        cdd = (r << 1) / 3;
        if (cdd > e83) cdd = e83;
      end
    end
    cd = clip(cdp > cdd ? cdp : cdd, sat);
    s = dim3 ? clip((qmul(d, d, sat) * PI4W) >> 62, sat) : d;
    a = qmul(qmul(qmul(cd, rho, sat), s, sat), norm, sat);
    for (int j = 0; j < 3; j++) begin
      o.f[j] = 0;
      if (j == 2 && !dim3) continue;
      m = clip((a * dm[j]) >> (FB + 1), sat);
      o.f[j] = (m != 0 && !dn[j]) ? -m[31:0] : m[31:0];
    end
    o.sat = sat;
    return o;
  endfunction

  always @(posedge clk) begin
    force_t e;
    logic [31:0] got [3];
    if (!rst && done) begin
      got[0] = force_x;
      got[1] = force_y;
      got[2] = force_z;
      if (pending_forces.size() == 0) begin
        $display("%0t: unexpected result %h %h %h %b", $time, force_x, force_y,
                 force_z, saturated);
        errors++;
      end else begin
        e = pending_forces.pop_front();
        for (int j = 0; j < 3; j++)
          if (got[j] !== e.f[j]) begin
            $display("%0t: force[%0d] exp %h got %h", $time, j, e.f[j], got[j]);
            errors++;
          end
        if (saturated !== e.sat) begin
          $display("%0t: saturated exp %b got %b", $time, e.sat, saturated);
          errors++;
        end
      end
    end
  end

  task automatic reg_write(logic [1:0] idx, logic [31:0] val);
    psel <= 1;
    penable <= 0;
    pwrite <= 1;
    paddr <= {idx, 2'b00};
    pwdata <= val;
    @(posedge clk);
    penable <= 1;
    do @(posedge clk); while (!pready);
    psel <= 0;
    penable <= 0;
    pwrite <= 0;
    case (idx)
      REG_GRAV:      grav = val[30:0];
      REG_SIGMA:     sigma = val[30:0];
      REG_TWO_PHASE: two_ph = val[0];
      REG_DIM3:      dim3 = val[0];
      default: ;
    endcase
  endtask

  task automatic send(particle_t p, bit known, force_t r);
    start <= 1;
    pvx <= p.pv[0]; pvy <= p.pv[1]; pvz <= p.pv[2];
    fvx <= p.fv[0]; fvy <= p.fv[1]; fvz <= p.fv[2];
    rho_i <= p.rho; mu_i <= p.mu; d_i <= p.d; rp_i <= p.rp;
    do @(posedge clk); while (busy);
    pending_forces.push_back(known ? r : drag_force(p));
    sent++;
  endtask

  task automatic gap(int pct);
    if ($urandom_range(0, 99) < pct) begin
      start <= 0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
  endtask

  task automatic drain();
    start <= 0;
    while (pending_forces.size() != 0) @(posedge clk);
    repeat (120) @(posedge clk);
  endtask

  function automatic logic [30:0] rnd_mag();
    logic [30:0] v;
    v = 31'($urandom);
    return ($urandom_range(0, 3) == 0) ? v : v >> $urandom_range(0, 30);
  endfunction

  function automatic logic signed [31:0] rnd_vel();
    logic [31:0] v;
    v = $urandom;
    if ($urandom_range(0, 3) == 0) return v;
    v = v >> $urandom_range(1, 31);
    return $urandom_range(0, 1) ? -v : v;
  endfunction

  function automatic row_t mk(int a, int b, int c, int e, int g, int h,
                              int r, int m, int dd, int q);
    row_t w;
    w.p.pv = '{a, b, c};
    w.p.fv = '{e, g, h};
    w.p.rho = 31'(r); w.p.mu = 31'(m); w.p.d = 31'(dd); w.p.rp = 31'(q);
    w.known = 0;
    w.r.f = '{0, 0, 0};
    w.r.sat = 0;
    return w;
  endfunction

  initial begin
    row_t tbl [$];
    row_t w;
    particle_t p;
    force_t nil;
    int one, mx, mn, pct;
    one = 1 << FB;
    mx = 32'h7FFF_FFFF;
    mn = 32'h8000_0000;
    nil.f = '{0, 0, 0};
    nil.sat = 0;

    w = mk(0, 0, 0, 0, 0, 0, 0, 1, 0, 0);
    w.known = 1; w.r.sat = 1;            // zero slip: Reynolds floor saturates Cd
    tbl.push_back(w);
    w = mk(0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
    w.known = 1;                         // zero viscosity, zero slip
    tbl.push_back(w);
    tbl.push_back(mk(one, 0, 0, 0, 0, 0, one, one, one, one));
    tbl.push_back(mk(-one, one, -one, 0, 0, one, one, one, one, 0));
    tbl.push_back(mk(one, 2 * one, 0, 0, 0, 0, one, 0, one, 0));
    tbl.push_back(mk(mn, 0, 0, mx, 0, 0, one, one, one, 0));
    tbl.push_back(mk(mx, mx, mx, mn, mn, mn, mx, mx, mx, mx));
    tbl.push_back(mk(mn, mn, mn, mn, mn, mn, mx, 1, mx, 0));
    tbl.push_back(mk(mn, 0, 0, 0, 0, 0, one, one, one, 0));
    tbl.push_back(mk(1, -1, 1, -1, 1, -1, 1, mx, 1, 1));
    tbl.push_back(mk(0, 0, 0, 0, 0, 0, mx, mx, mx, mx));
    tbl.push_back(mk(one / 4, -one / 8, one / 2, 0, one / 16, 0, 1000 * one, one / 1000,
                     one / 100, 2000 * one));
    tbl.push_back(mk(mx, 0, 0, 0, 0, 0, mx, mx, 0, mx));

    repeat (9) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    foreach (tbl[i]) send(tbl[i].p, tbl[i].known, tbl[i].r);
    drain();

    for (int ph = 0; ph < 5; ph++) begin
      case (ph)
        0: begin
          reg_write(REG_GRAV, mx); reg_write(REG_SIGMA, mx);
          reg_write(REG_TWO_PHASE, 1); reg_write(REG_DIM3, 1);
        end
        1: begin
          reg_write(REG_GRAV, $urandom); reg_write(REG_SIGMA, 0);
          reg_write(REG_DIM3, 0);
        end
        2: begin
          reg_write(REG_GRAV, 10 * one); reg_write(REG_SIGMA, one >> $urandom_range(0, 12));
          reg_write(REG_DIM3, 1);
        end
        3: begin
          reg_write(REG_GRAV, 0); reg_write(REG_SIGMA, $urandom);
          reg_write(REG_TWO_PHASE, 0); reg_write(REG_DIM3, 0);
        end
        default: begin
          reg_write(REG_GRAV, rnd_mag()); reg_write(REG_SIGMA, rnd_mag() | 1);
          reg_write(REG_TWO_PHASE, 1); reg_write(REG_DIM3, 1);
        end
      endcase
      for (int k = 0; k < 130; k++) begin
        for (int j = 0; j < 3; j++) begin
          p.pv[j] = rnd_vel();
          p.fv[j] = rnd_vel();
        end
        p.rho = rnd_mag();
        p.mu = rnd_mag();
        if (p.mu == 0) p.mu = 1;
        p.d = rnd_mag();
        p.rp = rnd_mag();
        pct = (sent < 230) ? 10 : (sent < 450) ? 52 : 0;
        gap(pct);
        send(p, 0, nil);
      end
      drain();
    end

    if (errors == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end

  initial begin
    #2000000;
    $display("RESULT: ERROR");
    $finish;
  end
endmodule

// File: sim.f
rtl/pdf_pkg.sv
rtl/pdf_regs.sv
rtl/pdf_cell.sv
rtl/particle_drag_force.sv
rtl/pdf_checker.sv
sim/tb.sv
